>>> rtl/core/lrfe_pkg.sv
`default_nettype none

package lrfe_pkg;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned STEP_W = 4;
    localparam int unsigned LVL_W  = 5;
    localparam int unsigned POS_W  = 5;

    localparam logic [1:0]        SPAWN_DROPS = 2'd3;
    localparam logic [STEP_W-1:0] STEP_RESET  = 4'd8;
    localparam logic [CH_W-1:0]   LEVEL_RESET = 8'd0;

    // Configuration register indexes
    localparam logic [1:0] REG_RED_STEP   = 2'd0;
    localparam logic [1:0] REG_GREEN_STEP = 2'd1;
    localparam logic [1:0] REG_BLUE_STEP  = 2'd2;
    localparam logic [1:0] REG_RELIGHT    = 2'd3;

    typedef struct packed {
        logic [1:0]      cnt;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_led;

    // level * step, saturated to one byte
    function automatic logic [CH_W-1:0] spawn_value(input logic [LVL_W-1:0] level,
                                                     input logic [STEP_W-1:0] step);
        logic [LVL_W+STEP_W-1:0] prod;
        prod = LVL_W'(level) * STEP_W'(step);
        return (prod > 9'd255) ? 8'hFF : prod[CH_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lrfe_cell.sv
`default_nettype none

module lrfe_cell (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_shift,
    input  lrfe_pkg::t_led i_d,
    input  wire            i_load,
    input  lrfe_pkg::t_led i_load_d,
    output lrfe_pkg::t_led o_q
);
    import lrfe_pkg::*;

    t_led r_led;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led <= '0;
        end else if (i_load) begin
            r_led <= i_load_d;
        end else if (i_shift) begin
            r_led <= i_d;
        end
    end

    assign o_q = r_led;

endmodule

`default_nettype wire

>>> rtl/core/lrfe_div.sv
`default_nettype none

module lrfe_div (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire [lrfe_pkg::CH_W-1:0]       i_dividend,
    input  wire [lrfe_pkg::STEP_W-1:0]     i_divisor,
    output logic [lrfe_pkg::CH_W-1:0]      o_quot,
    output logic                           o_done
);
    import lrfe_pkg::*;

    logic [CH_W-1:0]   r_q;
    logic [STEP_W-1:0] r_rem;
    logic [STEP_W-1:0] r_div;
    logic [3:0]        r_cnt;
    logic              r_busy;
    logic [STEP_W:0]   rem_sh;
    logic              q_bit;
    logic [STEP_W:0]   rem_sub;

    // restoring, one quotient bit per cycle; divisor zero yields all ones
    always_comb begin
        rem_sh  = {r_rem, r_q[CH_W-1]};
        q_bit   = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'(CH_W);
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[CH_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
            r_cnt <= r_cnt - 4'd1;
            if (r_cnt == 4'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_quot = r_q;
    assign o_done = !r_busy;

endmodule

`default_nettype wire

>>> rtl/core/lrfe_fade.sv
`default_nettype none

module lrfe_fade (
    input  lrfe_pkg::t_led                 i_cur,
    input  wire [lrfe_pkg::STEP_W-1:0]     i_red_step,
    input  wire [lrfe_pkg::STEP_W-1:0]     i_green_step,
    input  wire [lrfe_pkg::STEP_W-1:0]     i_blue_step,
    input  wire [lrfe_pkg::CH_W-1:0]       i_red_relight,
    input  wire [lrfe_pkg::CH_W-1:0]       i_green_relight,
    input  wire [lrfe_pkg::CH_W-1:0]       i_blue_relight,
    output lrfe_pkg::t_led                 o_nxt,
    output logic                           o_active
);
    import lrfe_pkg::*;

    function automatic logic [CH_W-1:0] fade(input logic [CH_W-1:0] ch,
                                             input logic [STEP_W-1:0] step);
        return (ch > CH_W'(step)) ? ch - CH_W'(step) : '0;
    endfunction

    logic [CH_W-1:0] red_f, green_f, blue_f;
    logic            all_dark;
    logic [1:0]      cnt_dec;

    always_comb begin
        red_f    = fade(i_cur.red, i_red_step);
        green_f  = fade(i_cur.green, i_green_step);
        blue_f   = fade(i_cur.blue, i_blue_step);
        all_dark = (red_f == '0) && (green_f == '0) && (blue_f == '0);
        cnt_dec  = i_cur.cnt - 2'd1;
        o_active = i_cur.cnt != 2'd0;

        o_nxt = i_cur;
        if (o_active) begin
            o_nxt.red   = red_f;
            o_nxt.green = green_f;
            o_nxt.blue  = blue_f;
            if (all_dark) begin
                o_nxt.cnt = cnt_dec;
                if (cnt_dec != 2'd0) begin
                    o_nxt.red   = i_red_relight;
                    o_nxt.green = i_green_relight;
                    o_nxt.blue  = i_blue_relight;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/led_raindrop_fade_effect_core.sv
// Tick: accept, then prep (the relight quotients are divided out while the spawn position is
//   wrapped by subtracting LED_COUNT; prep ends once both are done), then a walk step per LED,
//   a spawn step on spawning ticks, and a flush step that presents the tlast write.
// The ring rotates one LED per cycle, and output stalls hold it; a new request is taken only
//   in idle, after the flush.
// Reset (i_rst_n low, synchronous) clears colors, drop counts, parity; steps 8, relight 0.
`default_nettype none

module led_raindrop_fade_effect_core #(
    parameter int unsigned LED_COUNT = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request in
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [4:0] spawn_position, [9:5] spawn_level
    // LED writes out
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [4:0] led_index, [12:5] red_value,
                                        // [20:13] green_value, [28:21] blue_value
    output logic        m_axis_tlast,   // last_of_tick
    // configuration
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);
    import lrfe_pkg::*;

    localparam int unsigned CNT_W = (LED_COUNT > 1) ? $clog2(LED_COUNT + 1) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_WALK,
        S_SPAWN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] idx;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } t_res;

    t_state            r_state;
    logic              r_parity;
    logic              r_spawn;
    logic [POS_W-1:0]  r_pos;
    logic [LVL_W-1:0]  r_level;
    logic [CNT_W-1:0]  r_idx;
    logic [STEP_W-1:0] r_red_step, r_green_step, r_blue_step;
    logic [CH_W-1:0]   r_relight;
    t_res              r_pend;
    logic              r_pend_valid;
    t_res              r_out;
    logic              r_out_valid;
    logic              r_out_last;

    t_led              cell_q [LED_COUNT];
    t_led              fade_nxt;
    t_led              spawn_led;
    logic              fade_active;
    logic              out_free;
    logic              out_load;
    logic              emit_ok;
    logic              walk_step;
    logic              spawn_go;
    logic              accept;
    logic              pos_wrapped;
    logic [5:0]        idx_ext;
    t_res              walk_res;
    t_res              spawn_res;
    logic [CH_W-1:0]   red_q, green_q, blue_q;
    logic [2:0]        div_done;

    // ---------------- relight quotients ----------------
    lrfe_div u_div_red (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_dividend(r_relight), .i_divisor(r_red_step),
        .o_quot(red_q), .o_done(div_done[0])
    );
    lrfe_div u_div_green (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_dividend(r_relight), .i_divisor(r_green_step),
        .o_quot(green_q), .o_done(div_done[1])
    );
    lrfe_div u_div_blue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_dividend(r_relight), .i_divisor(r_blue_step),
        .o_quot(blue_q), .o_done(div_done[2])
    );

    // ---------------- fade unit at the ring head ----------------
    lrfe_fade u_fade (
        .i_cur(cell_q[0]),
        .i_red_step(r_red_step), .i_green_step(r_green_step), .i_blue_step(r_blue_step),
        .i_red_relight(red_q), .i_green_relight(green_q), .i_blue_relight(blue_q),
        .o_nxt(fade_nxt), .o_active(fade_active)
    );

    // ---------------- LED ring: cell k takes cell k+1, the tail takes the head ----------------
    always_comb begin
        spawn_led.cnt   = SPAWN_DROPS;
        spawn_led.red   = spawn_value(r_level, r_red_step);
        spawn_led.green = spawn_value(r_level, r_green_step);
        spawn_led.blue  = spawn_value(r_level, r_blue_step);
    end

    for (genvar k = 0; k < LED_COUNT; k++) begin : g_cell
        t_led shift_d;
        logic load;
        if (k == LED_COUNT - 1) begin : g_tail
            assign shift_d = fade_nxt;
        end else begin : g_body
            assign shift_d = cell_q[k+1];
        end
        assign load = spawn_go && ({1'b0, r_pos} == 6'(k));
        lrfe_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_shift(walk_step), .i_d(shift_d),
            .i_load(load), .i_load_d(spawn_led),
            .o_q(cell_q[k])
        );
    end

    // ---------------- control ----------------
    always_comb begin
        accept      = s_axis_tvalid && s_axis_tready;
        out_free    = !r_out_valid || m_axis_tready;
        emit_ok     = !r_pend_valid || out_free;
        walk_step   = (r_state == S_WALK) && (!fade_active || emit_ok);
        spawn_go    = (r_state == S_SPAWN) && emit_ok;
        // held result moves to the output register
        out_load    = r_pend_valid && ((walk_step && fade_active) || spawn_go ||
                                       ((r_state == S_FLUSH) && out_free));
        pos_wrapped = {1'b0, r_pos} < 6'(LED_COUNT);
        idx_ext     = 6'(r_idx);

        walk_res.idx   = idx_ext[POS_W-1:0];
        walk_res.red   = fade_nxt.red;
        walk_res.green = fade_nxt.green;
        walk_res.blue  = fade_nxt.blue;

        spawn_res.idx   = r_pos;
        spawn_res.red   = spawn_led.red;
        spawn_res.green = spawn_led.green;
        spawn_res.blue  = spawn_led.blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_parity     <= 1'b0;
            r_spawn      <= 1'b0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
            r_red_step   <= STEP_RESET;
            r_green_step <= STEP_RESET;
            r_blue_step  <= STEP_RESET;
            r_relight    <= LEVEL_RESET;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_RED_STEP:   r_red_step   <= i_cfg_data[STEP_W-1:0];
                    REG_GREEN_STEP: r_green_step <= i_cfg_data[STEP_W-1:0];
                    REG_BLUE_STEP:  r_blue_step  <= i_cfg_data[STEP_W-1:0];
                    REG_RELIGHT:    r_relight    <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_parity <= !r_parity;
                        r_spawn  <= r_parity;   // toggled parity becomes zero
                        r_pos    <= s_axis_tdata[4:0];
                        r_level  <= s_axis_tdata[9:5];
                        r_idx    <= '0;
                        r_state  <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (!pos_wrapped) begin
                        r_pos <= POS_W'({1'b0, r_pos} - 6'(LED_COUNT));
                    end else if (&div_done) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (walk_step) begin
                        r_idx <= r_idx + CNT_W'(1);
                        if (fade_active) begin
                            if (r_pend_valid) begin
                                r_out       <= r_pend;
                                r_out_last  <= 1'b0;
                            end
                            r_pend       <= walk_res;
                            r_pend_valid <= 1'b1;
                        end
                        if (r_idx == CNT_W'(LED_COUNT - 1)) begin
                            r_state <= r_spawn ? S_SPAWN : S_FLUSH;
                        end
                    end
                end
                S_SPAWN: begin
                    if (spawn_go) begin
                        if (r_pend_valid) begin
                            r_out       <= r_pend;
                            r_out_last  <= 1'b0;
                        end
                        r_pend       <= spawn_res;
                        r_pend_valid <= 1'b1;
                        r_state      <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    // held result is the tick's final one
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out        <= r_pend;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {3'b000, r_out.blue, r_out.green, r_out.red, r_out.idx};

    // ---------------- assertions ----------------
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("held result left over in idle");

    a_walk_pos_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> pos_wrapped)
        else $error("spawn position not wrapped before walk");

    a_walk_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (&div_done))
        else $error("walk started before relight division finished");

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_PREP) && !(&div_done))
        else $error("tick accepted without starting division");

endmodule

`default_nettype wire
